FILE: hdl/cbps_pkg.sv
package cbps_pkg;

  localparam int K_W      = 17;
  localparam int CTRL_W   = 16;
  localparam int SEG_W    = 16;
  localparam int T_W      = 18;
  localparam int CURVE_W  = 23;
  localparam int INV_W    = 28;
  localparam int INV_Q_W  = 27;
  localparam int FRAC_BITS = 12;
  localparam int MAX_POINTS = 65536;
  localparam int T_ONE    = 65536;
  // magnitude of -100 in Q.8, scaled for a Q.FRAC_BITS divisor
  localparam int INV_LIMIT = 100 << (8 + FRAC_BITS);

  typedef enum logic [2:0] {
    REG_CTRL_START = 3'd0,
    REG_CTRL_ONE   = 3'd1,
    REG_CTRL_TWO   = 3'd2,
    REG_CTRL_END   = 3'd3,
    REG_START_TICK = 3'd4,
    REG_END_TICK   = 3'd5,
    REG_SEGMENTS   = 3'd6
  } cbps_reg_t;

  typedef struct packed {
    logic pv;
    logic last;
  } cbps_flags_t;

endpackage

FILE: hdl/cbps_div_cell.sv
module cbps_div_cell import cbps_pkg::*; #(
  parameter int DEN_W  = 16,
  parameter int Q_W    = 18,
  parameter int SIDE_W = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              vld_in,
  input  logic [DEN_W-1:0]  rem_in,
  input  logic [Q_W-1:0]    num_in,
  input  logic [Q_W-1:0]    quo_in,
  input  logic [DEN_W-1:0]  den_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              vld,
  output logic [DEN_W-1:0]  rem,
  output logic [Q_W-1:0]    num,
  output logic [Q_W-1:0]    quo,
  output logic [DEN_W-1:0]  den,
  output logic [SIDE_W-1:0] side
);

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  // one restoring step: bring down the next numerator bit
  always_comb begin
    trial    = {rem_in, num_in[Q_W-1]};
    ge       = trial >= {1'b0, den_in};
    rem_next = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem  <= rem_next;
      num  <= {num_in[Q_W-2:0], 1'b0};
      quo  <= {quo_in[Q_W-2:0], ge};
      den  <= den_in;
      side <= side_in;
    end
  end

endmodule

FILE: hdl/cbps_div_chain.sv
module cbps_div_chain import cbps_pkg::*; #(
  parameter int DEN_W  = 16,
  parameter int Q_W    = 18,
  parameter int SIDE_W = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              vld_in,
  input  logic [DEN_W-1:0]  rem_in,
  input  logic [Q_W-1:0]    num_in,
  input  logic [DEN_W-1:0]  den_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              vld,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] side
);

  logic              c_vld  [0:Q_W];
  logic [DEN_W-1:0]  c_rem  [0:Q_W];
  logic [Q_W-1:0]    c_num  [0:Q_W];
  logic [Q_W-1:0]    c_quo  [0:Q_W];
  logic [DEN_W-1:0]  c_den  [0:Q_W];
  logic [SIDE_W-1:0] c_side [0:Q_W];

  assign c_vld[0]  = vld_in;
  assign c_rem[0]  = rem_in;
  assign c_num[0]  = num_in;
  assign c_quo[0]  = '0;
  assign c_den[0]  = den_in;
  assign c_side[0] = side_in;

  // one cell per quotient bit, MSB first
  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    cbps_div_cell #(.DEN_W(DEN_W), .Q_W(Q_W), .SIDE_W(SIDE_W)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .vld_in (c_vld[i]),
      .rem_in (c_rem[i]),
      .num_in (c_num[i]),
      .quo_in (c_quo[i]),
      .den_in (c_den[i]),
      .side_in(c_side[i]),
      .vld    (c_vld[i+1]),
      .rem    (c_rem[i+1]),
      .num    (c_num[i+1]),
      .quo    (c_quo[i+1]),
      .den    (c_den[i+1]),
      .side   (c_side[i+1])
    );
  end

  assign vld  = c_vld[Q_W];
  assign quo  = c_quo[Q_W];
  assign side = c_side[Q_W];

endmodule

FILE: hdl/cubic_bezier_point_sampler.sv
// Cubic Bezier point sampler. Each accepted point_index k yields one result item:
// the tick start + (end - start) * k / segments, the curve value B(t) in Q10.12 and
// -100 / B(t) in Q.8. One item is taken every clock cycle unless held; the result
// passes through 18 cells of the t divider, four multiply/sum stages, 27 cells of
// the reciprocal divider and one output register. The whole row moves together:
// out_stall on a valid output holds it and shows on in_stall in the same cycle.
module cubic_bezier_point_sampler import cbps_pkg::*; #(
  parameter int TICK_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_write,
  input  logic [2:0]                  cfg_index,
  input  logic [TICK_BITS-1:0]        cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [K_W-1:0]              point_index,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [TICK_BITS-1:0]        tick_out,
  output logic signed [CURVE_W-1:0]   curve_value,
  output logic signed [INV_W-1:0]     scaled_inverse,
  output logic                        point_valid,
  output logic                        last_point,
  output logic                        zero_value
);

  localparam int TP_W = TICK_BITS + 20;   // (end - start) * t
  localparam int TS_W = TICK_BITS + 21;   // start + slope part
  localparam int SIDE2_W = TICK_BITS + CURVE_W + $bits(cbps_flags_t);

  // ---------------------------------------------------------------- config
  logic [CTRL_W-1:0]    ctrl_start, ctrl_one, ctrl_two, ctrl_end;
  logic [TICK_BITS-1:0] start_tick, end_tick;
  logic [SEG_W-1:0]     segments;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_start <= CTRL_W'(4096);
      ctrl_one   <= CTRL_W'(4096);
      ctrl_two   <= CTRL_W'(4096);
      ctrl_end   <= CTRL_W'(4096);
      start_tick <= '0;
      end_tick   <= '0;
      segments   <= '0;
    end else if (cfg_write) begin
      unique case (cbps_reg_t'(cfg_index))
        REG_CTRL_START: ctrl_start <= cfg_data[CTRL_W-1:0];
        REG_CTRL_ONE:   ctrl_one   <= cfg_data[CTRL_W-1:0];
        REG_CTRL_TWO:   ctrl_two   <= cfg_data[CTRL_W-1:0];
        REG_CTRL_END:   ctrl_end   <= cfg_data[CTRL_W-1:0];
        REG_START_TICK: start_tick <= cfg_data;
        REG_END_TICK:   end_tick   <= cfg_data;
        REG_SEGMENTS:   segments   <= cfg_data[SEG_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // whole pipeline steps unless a finished item is held at the output
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------------------------------------------------------- entry
  cbps_flags_t in_flags;
  logic        cfg_ok;
  logic [K_W-1:0] seg_p1;

  always_comb begin
    cfg_ok       = (start_tick != '0) && (end_tick != '0) && (segments != '0);
    seg_p1       = K_W'({1'b0, segments} + 17'd1);
    in_flags.pv  = cfg_ok && (point_index <= seg_p1)
                   && (32'(point_index) <= 32'(MAX_POINTS));
    in_flags.last = in_flags.pv && (point_index == seg_p1);
  end

  // t = (k << 16) / segments; t < 2^18 on every valid point, so the top
  // numerator bits start off as the partial remainder
  logic              d1_vld;
  logic [T_W-1:0]    d1_t;
  cbps_flags_t       d1_flags;

  cbps_div_chain #(.DEN_W(SEG_W), .Q_W(T_W), .SIDE_W($bits(cbps_flags_t))) u_tdiv (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .vld_in (in_valid),
    .rem_in ({1'b0, point_index[K_W-1:2]}),
    .num_in ({point_index[1:0], 16'd0}),
    .den_in (segments),
    .side_in(in_flags),
    .vld    (d1_vld),
    .quo    (d1_t),
    .side   (d1_flags)
  );

  // ---------------------------------------------------------------- stage A
  logic signed [18:0]   u_c;
  logic signed [37:0]   uu_full, ut_full;
  logic [35:0]          tt_full;
  logic signed [TICK_BITS:0] diff;
  logic signed [TP_W-1:0]    dt_full;

  always_comb begin
    u_c     = $signed(19'(T_ONE)) - $signed({1'b0, d1_t});
    uu_full = u_c * u_c;
    ut_full = u_c * $signed({1'b0, d1_t});
    tt_full = d1_t * d1_t;
    diff    = $signed({1'b0, end_tick}) - $signed({1'b0, start_tick});
    dt_full = diff * $signed({1'b0, d1_t});
  end

  logic                  a_vld;
  cbps_flags_t           a_flags;
  logic signed [33:0]    a_uu;
  logic signed [34:0]    a_ut;
  logic [34:0]           a_tt;
  logic signed [18:0]    a_u;
  logic [T_W-1:0]        a_t;
  logic signed [TP_W-1:0] a_dt;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (adv) a_vld <= d1_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_flags <= d1_flags;
      a_uu    <= uu_full[33:0];
      a_ut    <= ut_full[34:0];
      a_tt    <= tt_full[34:0];
      a_u     <= u_c;
      a_t     <= d1_t;
      a_dt    <= dt_full;
    end
  end

  // ---------------------------------------------------------------- stage B
  logic signed [52:0] u3;
  logic signed [52:0] uut;
  logic signed [54:0] uut3;
  logic signed [53:0] utt;
  logic signed [55:0] utt3;
  logic [52:0]        t3;
  logic signed [37:0] w0_c, w1_c, w2_c, w3_c;
  logic signed [52:0] u3_s;
  logic signed [54:0] uut3_s;
  logic signed [55:0] utt3_s;
  logic signed [TS_W-1:0] tsum;
  logic [TICK_BITS-1:0]   tick_c;

  always_comb begin
    u3     = a_uu * a_u;
    uut    = a_uu * $signed({1'b0, a_t});
    uut3   = (uut <<< 1) + uut;
    utt    = a_ut * $signed({1'b0, a_t});
    utt3   = (utt <<< 1) + utt;
    t3     = a_tt * a_t;
    u3_s   = u3 >>> 16;
    uut3_s = uut3 >>> 16;
    utt3_s = utt3 >>> 16;
    w0_c   = u3_s[37:0];
    w1_c   = uut3_s[37:0];
    w2_c   = utt3_s[37:0];
    w3_c   = $signed({1'b0, t3[52:16]});
    tsum   = $signed({1'b0, start_tick}) + (a_dt >>> 16);
    if (tsum[TS_W-1]) begin
      tick_c = '0;
    end else if (tsum[TS_W-2:TICK_BITS] != '0) begin
      tick_c = '1;
    end else begin
      tick_c = tsum[TICK_BITS-1:0];
    end
  end

  logic                 b_vld;
  cbps_flags_t          b_flags;
  logic signed [37:0]   b_w0, b_w1, b_w2, b_w3;
  logic [TICK_BITS-1:0] b_tick;

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (adv) b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_flags <= a_flags;
      b_w0    <= w0_c;
      b_w1    <= w1_c;
      b_w2    <= w2_c;
      b_w3    <= w3_c;
      b_tick  <= tick_c;
    end
  end

  // ---------------------------------------------------------------- stage C
  logic                 c_vld;
  cbps_flags_t          c_flags;
  logic signed [54:0]   c_p0, c_p1, c_p2, c_p3;
  logic [TICK_BITS-1:0] c_tick;

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else if (adv) c_vld <= b_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_flags <= b_flags;
      c_p0    <= b_w0 * $signed({1'b0, ctrl_start});
      c_p1    <= b_w1 * $signed({1'b0, ctrl_one});
      c_p2    <= b_w2 * $signed({1'b0, ctrl_two});
      c_p3    <= b_w3 * $signed({1'b0, ctrl_end});
      c_tick  <= b_tick;
    end
  end

  // ---------------------------------------------------------------- stage D
  logic signed [56:0] sum;
  logic signed [56:0] sum_s;
  logic signed [CURVE_W-1:0] curve_c;

  always_comb begin
    // round half up, then saturate to Q10.12
    sum   = c_p0 + c_p1 + c_p2 + c_p3 + $signed(57'(64'd1 << 31));
    sum_s = sum >>> 32;
    if (sum_s > $signed(57'((1 << (CURVE_W - 1)) - 1))) begin
      curve_c = $signed(CURVE_W'((1 << (CURVE_W - 1)) - 1));
    end else if (sum_s < -$signed(57'(1 << (CURVE_W - 1)))) begin
      curve_c = $signed({1'b1, {(CURVE_W-1){1'b0}}});
    end else begin
      curve_c = sum_s[CURVE_W-1:0];
    end
  end

  logic                      dd_vld;
  cbps_flags_t               dd_flags;
  logic signed [CURVE_W-1:0] dd_curve;
  logic [TICK_BITS-1:0]      dd_tick;

  always_ff @(posedge clk) begin
    if (rst) dd_vld <= 1'b0;
    else if (adv) dd_vld <= c_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dd_flags <= c_flags;
      dd_curve <= curve_c;
      dd_tick  <= c_tick;
    end
  end

  // ---------------------------------------------------------------- reciprocal
  logic [CURVE_W-1:0] mag;
  assign mag = dd_curve[CURVE_W-1] ? CURVE_W'(~dd_curve + 1'b1) : dd_curve;

  logic                 d2_vld;
  logic [INV_Q_W-1:0]   d2_quo;
  logic [SIDE2_W-1:0]   d2_side;

  cbps_div_chain #(.DEN_W(CURVE_W), .Q_W(INV_Q_W), .SIDE_W(SIDE2_W)) u_idiv (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .vld_in (dd_vld),
    .rem_in ('0),
    .num_in (INV_Q_W'(INV_LIMIT)),
    .den_in (mag),
    .side_in({dd_tick, dd_curve, dd_flags}),
    .vld    (d2_vld),
    .quo    (d2_quo),
    .side   (d2_side)
  );

  // ---------------------------------------------------------------- output
  logic [TICK_BITS-1:0]      e_tick;
  logic signed [CURVE_W-1:0] e_curve;
  cbps_flags_t               e_flags;
  logic                      e_zero;
  logic signed [INV_W-1:0]   e_inv;

  always_comb begin
    {e_tick, e_curve, e_flags} = d2_side;
    e_zero = (e_curve == '0);
    if (e_zero) begin
      e_inv = -$signed(INV_W'(INV_LIMIT));
    end else if (e_curve[CURVE_W-1]) begin
      e_inv = $signed({1'b0, d2_quo});
    end else begin
      e_inv = -$signed({1'b0, d2_quo});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= d2_vld;
  end

  // out-of-range or unset configuration: every field reads as zero
  always_ff @(posedge clk) begin
    if (adv) begin
      tick_out       <= e_flags.pv ? e_tick : '0;
      curve_value    <= e_flags.pv ? e_curve : '0;
      scaled_inverse <= e_flags.pv ? e_inv : '0;
      point_valid    <= e_flags.pv;
      last_point     <= e_flags.last;
      zero_value     <= e_flags.pv && e_zero;
    end
  end

endmodule
